[sv/accel_tilt_roll_pitch_defines.svh]
// assertion macros shared by the tilt block
`ifndef ACCEL_TILT_ROLL_PITCH_DEFINES_SVH
`define ACCEL_TILT_ROLL_PITCH_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ATRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atrp: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ATRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("atrp: next-cycle check failed");

`endif

[sv/atrp_pkg.sv]
package atrp_pkg;

    // iteration counts
    localparam int CORDIC_STEPS = 20;
    localparam int CORD_MAX     = 32;
    localparam int CORD_USED    = (CORDIC_STEPS > CORD_MAX) ? CORD_MAX : CORDIC_STEPS;
    localparam int SQRT_STEPS   = 32;
    localparam int STEP_W       = $clog2(CORD_MAX);

    // fixed point layout
    localparam int ANG_FRAC = 16;
    localparam int VEC_FRAC = 24;
    localparam int AXIS_W   = 16;
    localparam int NEG_W    = AXIS_W + 1;
    localparam int VEC_W    = 42;
    localparam int ANG_W    = 32;
    localparam int RAD_W    = 32;
    localparam int REM_W    = 34;
    localparam int ROOT_W   = 32;
    localparam int ROLL_W   = 16;
    localparam int PITCH_W  = 15;

    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;

    typedef logic signed [ANG_W-1:0] t_ang;

    localparam t_ang HALF_TURN_Q = t_ang'(HALF_TURN * (2 ** ANG_FRAC));

    // atan(2^-i) in centidegrees, 16 fractional bits
    localparam t_ang ATAN_TAB [0:CORD_MAX-1] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11,
        6, 3, 1, 1, 0, 0
    };

    // values that ride along the root chain
    typedef struct packed {
        logic signed [NEG_W-1:0] nx;
        logic signed [NEG_W-1:0] rvx;
        logic signed [NEG_W-1:0] rvy;
        t_ang                    roll_off;
        logic                    roll_zero;
        logic                    pitch_zero;
    } t_side;

    // one cell of the square root chain
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        t_side             side;
    } t_sqrt;

    // one cell of the rotation chain, roll and pitch lanes
    typedef struct packed {
        logic signed [VEC_W-1:0] roll_x;
        logic signed [VEC_W-1:0] roll_y;
        t_ang                    roll_ang;
        logic signed [VEC_W-1:0] pit_x;
        logic signed [VEC_W-1:0] pit_y;
        t_ang                    pit_ang;
        logic                    roll_zero;
        logic                    pitch_zero;
    } t_cord;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
    } t_res;

endpackage

[sv/atrp_prep.sv]
module atrp_prep (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [atrp_pkg::AXIS_W-1:0]   i_x,
    input  logic signed [atrp_pkg::AXIS_W-1:0]   i_y,
    input  logic signed [atrp_pkg::AXIS_W-1:0]   i_z,
    output logic                                 o_valid,
    output atrp_pkg::t_sqrt                      o_data
);

    logic                                 r_valid;
    atrp_pkg::t_sqrt                      r_data;
    atrp_pkg::t_sqrt                      n_data;
    logic signed [2*atrp_pkg::AXIS_W-1:0] yy;
    logic signed [2*atrp_pkg::AXIS_W-1:0] zz;
    logic signed [atrp_pkg::NEG_W-1:0]    sx;
    logic signed [atrp_pkg::NEG_W-1:0]    sy;
    logic signed [atrp_pkg::NEG_W-1:0]    sz;

    // squares, folded roll vector and flags
    always_comb begin
        sx = {i_x[atrp_pkg::AXIS_W-1], i_x};
        sy = {i_y[atrp_pkg::AXIS_W-1], i_y};
        sz = {i_z[atrp_pkg::AXIS_W-1], i_z};
        yy = i_y * i_y;
        zz = i_z * i_z;
        n_data.rad  = atrp_pkg::RAD_W'(yy) + atrp_pkg::RAD_W'(zz);
        n_data.rem  = '0;
        n_data.root = '0;
        n_data.side.nx = -sx;
        // left half plane goes through a half turn so the cordic sees x >= 0
        if (i_z[atrp_pkg::AXIS_W-1]) begin
            n_data.side.rvx      = -sz;
            n_data.side.rvy      = -sy;
            n_data.side.roll_off = i_y[atrp_pkg::AXIS_W-1] ? -atrp_pkg::HALF_TURN_Q
                                                          : atrp_pkg::HALF_TURN_Q;
        end else begin
            n_data.side.rvx      = sz;
            n_data.side.rvy      = sy;
            n_data.side.roll_off = '0;
        end
        n_data.side.roll_zero  = (i_y == '0) && (i_z == '0);
        n_data.side.pitch_zero = (i_x == '0) && (i_y == '0) && (i_z == '0);
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/atrp_sqrt_cell.sv]
module atrp_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  atrp_pkg::t_sqrt i_data,
    output logic            o_valid,
    output atrp_pkg::t_sqrt o_data
);

    logic                          r_valid;
    atrp_pkg::t_sqrt               r_data;
    atrp_pkg::t_sqrt               n_data;
    logic [atrp_pkg::REM_W+1:0]    rem_sh;
    logic [atrp_pkg::REM_W+1:0]    trial;

    // one root bit: bring in two radicand bits, try to subtract
    always_comb begin
        rem_sh = {i_data.rem, i_data.rad[atrp_pkg::RAD_W-1 -: 2]};
        trial  = {2'b00, i_data.root, 2'b01};
        n_data.side = i_data.side;
        n_data.rad  = {i_data.rad[atrp_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = atrp_pkg::REM_W'(rem_sh - trial);
            n_data.root = {i_data.root[atrp_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh[atrp_pkg::REM_W-1:0];
            n_data.root = {i_data.root[atrp_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/atrp_cordic_cell.sv]
module atrp_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [atrp_pkg::STEP_W-1:0] i_step,
    input  logic                        i_valid,
    input  atrp_pkg::t_cord             i_data,
    output logic                        o_valid,
    output atrp_pkg::t_cord             o_data
);

    logic                              r_valid;
    atrp_pkg::t_cord                   r_data;
    atrp_pkg::t_cord                   n_data;
    logic signed [atrp_pkg::VEC_W-1:0] r_dx;
    logic signed [atrp_pkg::VEC_W-1:0] r_dy;
    logic signed [atrp_pkg::VEC_W-1:0] p_dx;
    logic signed [atrp_pkg::VEC_W-1:0] p_dy;
    atrp_pkg::t_ang                    step_ang;

    // one vectoring rotation on each lane, driving y toward zero
    always_comb begin
        step_ang = atrp_pkg::ATAN_TAB[i_step];
        r_dx = $signed(i_data.roll_y) >>> i_step;
        r_dy = $signed(i_data.roll_x) >>> i_step;
        p_dx = $signed(i_data.pit_y) >>> i_step;
        p_dy = $signed(i_data.pit_x) >>> i_step;
        n_data = i_data;
        if (!i_data.roll_y[atrp_pkg::VEC_W-1]) begin
            n_data.roll_x   = i_data.roll_x + r_dx;
            n_data.roll_y   = i_data.roll_y - r_dy;
            n_data.roll_ang = i_data.roll_ang + step_ang;
        end else begin
            n_data.roll_x   = i_data.roll_x - r_dx;
            n_data.roll_y   = i_data.roll_y + r_dy;
            n_data.roll_ang = i_data.roll_ang - step_ang;
        end
        if (!i_data.pit_y[atrp_pkg::VEC_W-1]) begin
            n_data.pit_x   = i_data.pit_x + p_dx;
            n_data.pit_y   = i_data.pit_y - p_dy;
            n_data.pit_ang = i_data.pit_ang + step_ang;
        end else begin
            n_data.pit_x   = i_data.pit_x - p_dx;
            n_data.pit_y   = i_data.pit_y + p_dy;
            n_data.pit_ang = i_data.pit_ang - step_ang;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/atrp_finish.sv]
module atrp_finish (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  atrp_pkg::t_cord i_data,
    output logic            o_valid,
    output atrp_pkg::t_res  o_data
);

    logic           r_valid;
    atrp_pkg::t_res r_data;
    atrp_pkg::t_res n_data;

    // drop the fraction toward zero and clamp to the legal angle range
    function automatic logic signed [atrp_pkg::ROLL_W-1:0] centi(
        input atrp_pkg::t_ang               ang,
        input logic [atrp_pkg::ROLL_W-1:0]  lim
    );
        logic [atrp_pkg::ANG_W-1:0]  mag;
        logic [atrp_pkg::ROLL_W-1:0] c;
        mag = ang[atrp_pkg::ANG_W-1] ? atrp_pkg::ANG_W'(-ang) : atrp_pkg::ANG_W'(ang);
        c   = mag[atrp_pkg::ANG_W-1 -: atrp_pkg::ROLL_W];
        if (c > lim) begin
            c = lim;
        end
        return ang[atrp_pkg::ANG_W-1] ? -$signed(c) : $signed(c);
    endfunction

    // both angles, zeroed when the operands were all zero
    always_comb begin
        n_data.roll  = i_data.roll_zero ? '0
                     : centi(i_data.roll_ang, atrp_pkg::ROLL_W'(atrp_pkg::HALF_TURN));
        n_data.pitch = i_data.pitch_zero ? '0
                     : atrp_pkg::PITCH_W'(centi(i_data.pit_ang,
                                                atrp_pkg::ROLL_W'(atrp_pkg::QUARTER_TURN)));
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[sv/accel_tilt_roll_pitch.sv]
// Throughput: one item per clock; a new sample is taken every cycle unless the skid stage is full.
// Pipeline from the accepting edge to o_m_axis_tvalid: one entry register, 32 root cells
// (one root bit each), CORDIC_STEPS rotation cells (20 by default), one rounding register, one
// output register.
// Reset: synchronous, active low; clears every stage valid bit and the output and skid valid bits.
`include "accel_tilt_roll_pitch_defines.svh"

module accel_tilt_roll_pitch (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // roll_centideg[15:0], pitch_centideg[30:16], zero[31]
);

    localparam int SN = atrp_pkg::SQRT_STEPS;
    localparam int CN = atrp_pkg::CORD_USED;
    localparam int RX_PAD = atrp_pkg::VEC_W - atrp_pkg::NEG_W - atrp_pkg::VEC_FRAC;
    localparam int PX_SH  = atrp_pkg::VEC_FRAC - atrp_pkg::ANG_FRAC;
    localparam int PX_PAD = atrp_pkg::VEC_W - atrp_pkg::ROOT_W - PX_SH;

    logic            en;
    logic            sq_valid [0:SN];
    atrp_pkg::t_sqrt sq_data  [0:SN];
    logic            cd_valid [0:CN];
    atrp_pkg::t_cord cd_data  [0:CN];
    logic            fin_valid;
    atrp_pkg::t_res  fin_data;
    logic            r_out_valid;
    atrp_pkg::t_res  r_out_data;
    logic            r_skid_valid;
    atrp_pkg::t_res  r_skid_data;

    // the chain moves whenever the skid stage has room
    assign en              = !r_skid_valid;
    assign o_s_axis_tready = en;

    atrp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[15:0]),
        .i_y     (i_s_axis_tdata[31:16]),
        .i_z     (i_s_axis_tdata[47:32]),
        .o_valid (sq_valid[0]),
        .o_data  (sq_data[0])
    );

    // root chain: magnitude of (y, z) with 16 fractional bits
    for (genvar k = 0; k < SN; k++) begin : g_sqrt
        atrp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[k]),
            .i_data  (sq_data[k]),
            .o_valid (sq_valid[k+1]),
            .o_data  (sq_data[k+1])
        );
    end

    // scale both vectors to the rotation datapath
    always_comb begin
        cd_valid[0]           = sq_valid[SN];
        cd_data[0].roll_x     = {{RX_PAD{sq_data[SN].side.rvx[atrp_pkg::NEG_W-1]}},
                                 sq_data[SN].side.rvx, {atrp_pkg::VEC_FRAC{1'b0}}};
        cd_data[0].roll_y     = {{RX_PAD{sq_data[SN].side.rvy[atrp_pkg::NEG_W-1]}},
                                 sq_data[SN].side.rvy, {atrp_pkg::VEC_FRAC{1'b0}}};
        cd_data[0].roll_ang   = sq_data[SN].side.roll_off;
        cd_data[0].pit_x      = {{PX_PAD{1'b0}}, sq_data[SN].root, {PX_SH{1'b0}}};
        cd_data[0].pit_y      = {{RX_PAD{sq_data[SN].side.nx[atrp_pkg::NEG_W-1]}},
                                 sq_data[SN].side.nx, {atrp_pkg::VEC_FRAC{1'b0}}};
        cd_data[0].pit_ang    = '0;
        cd_data[0].roll_zero  = sq_data[SN].side.roll_zero;
        cd_data[0].pitch_zero = sq_data[SN].side.pitch_zero;
    end

    // rotation chain, one micro-rotation per cell
    for (genvar k = 0; k < CN; k++) begin : g_cordic
        atrp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (atrp_pkg::STEP_W'(k)),
            .i_valid (cd_valid[k]),
            .i_data  (cd_data[k]),
            .o_valid (cd_valid[k+1]),
            .o_data  (cd_data[k+1])
        );
    end

    atrp_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cd_valid[CN]),
        .i_data  (cd_data[CN]),
        .o_valid (fin_valid),
        .o_data  (fin_data)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= fin_valid;
            end
        end else if (fin_valid && en) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out_data <= r_skid_valid ? r_skid_data : fin_data;
        end else if (fin_valid && en) begin
            r_skid_data <= fin_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_data.pitch, r_out_data.roll};

    // checks
    `ATRP_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ATRP_ASSERT_NXT(a_skid_holds, i_clk, i_rst_n, r_skid_valid && !i_m_axis_tready, r_skid_valid && $stable(r_skid_data))
    `ATRP_ASSERT_IMP(a_roll_range, i_clk, i_rst_n, r_out_valid, (r_out_data.roll >= -16'sd18000) && (r_out_data.roll <= 16'sd18000))
    `ATRP_ASSERT_IMP(a_zero_root, i_clk, i_rst_n, sq_valid[SN] && sq_data[SN].side.roll_zero, sq_data[SN].root == '0)

endmodule

[sim/accel_tilt_roll_pitch_tb.sv]
module accel_tilt_roll_pitch_tb;

    // tilt angle checker: predicts roll and pitch per sample and matches results in order
    class tilt_scoreboard;
        atrp_pkg::t_res pending[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        // one line per mismatch
        task report(input string msg);
            errors++;
            $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
        endtask

        // bitwise integer square root of a 64-bit value
        function longint unsigned int_root(input longint unsigned n);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) begin
                bitv = bitv >> 2;
            end
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // vectoring rotation, angle of (vx, vy) in q16 centidegrees
        function longint vector_angle(input longint vx, input longint vy);
            longint ang;
            longint dx;
            longint dy;
            ang = 0;
            for (int i = 0; i < atrp_pkg::CORD_USED; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (vy >= 0) begin
                    vx  = vx + dx;
                    vy  = vy - dy;
                    ang = ang + longint'(atrp_pkg::ATAN_TAB[i]);
                end else begin
                    vx  = vx - dx;
                    vy  = vy + dy;
                    ang = ang - longint'(atrp_pkg::ATAN_TAB[i]);
                end
            end
            return ang;
        endfunction

        // drop the fraction toward zero and clamp to the angle range
        function longint whole_centideg(input longint ang, input longint lim);
            longint c;
            if (ang >= 0) begin
                c = ang >>> atrp_pkg::ANG_FRAC;
            end else begin
                c = -((-ang) >>> atrp_pkg::ANG_FRAC);
            end
            if (c > lim) begin
                c = lim;
            end
            if (c < -lim) begin
                c = -lim;
            end
            return c;
        endfunction

        function atrp_pkg::t_res tilt_angles(input logic [47:0] sample);
            logic signed [15:0] ax;
            logic signed [15:0] ay;
            logic signed [15:0] az;
            longint             xs;
            longint             ys;
            longint             zs;
            longint             nx;
            longint             vx;
            longint             vy;
            longint             off;
            longint             roll;
            longint             pitch;
            longint unsigned    mag2;
            longint             r16;
            atrp_pkg::t_res     res;
            ax = sample[15:0];
            ay = sample[31:16];
            az = sample[47:32];
            xs = ax;
            ys = ay;
            zs = az;
            nx = -xs;
            roll  = 0;
            pitch = 0;
            mag2 = longint'(ys * ys) + longint'(zs * zs);
            r16  = longint'(int_root(mag2 << 32));
            // roll: fold the left half plane onto the right and add a half turn
            if (ys != 0 || zs != 0) begin
                vx  = zs;
                vy  = ys;
                off = 0;
                if (zs < 0) begin
                    vx  = -zs;
                    vy  = -ys;
                    off = (ys >= 0) ? (longint'(atrp_pkg::HALF_TURN) <<< atrp_pkg::ANG_FRAC)
                                    : -(longint'(atrp_pkg::HALF_TURN) <<< atrp_pkg::ANG_FRAC);
                end
                roll = whole_centideg(off + vector_angle(vx <<< atrp_pkg::VEC_FRAC,
                                                         vy <<< atrp_pkg::VEC_FRAC),
                                      atrp_pkg::HALF_TURN);
            end
            // pitch: magnitude carries 16 fraction bits already
            if (nx != 0 || r16 != 0) begin
                pitch = whole_centideg(vector_angle(r16 <<< (atrp_pkg::VEC_FRAC - 16),
                                                    nx <<< atrp_pkg::VEC_FRAC),
                                       atrp_pkg::QUARTER_TURN);
            end
            res.roll  = roll[atrp_pkg::ROLL_W-1:0];
            res.pitch = pitch[atrp_pkg::PITCH_W-1:0];
            return res;
        endfunction

        function void note_sample(input logic [47:0] sample);
            pending.push_back(tilt_angles(sample));
        endfunction

        task check_result(input logic [31:0] data);
            atrp_pkg::t_res want;
            if (pending.size() == 0) begin
                report($sformatf("result %h with no sample waiting", data));
            end else begin
                want = pending.pop_front();
                if (data[15:0] !== want.roll) begin
                    report($sformatf("roll %0d, predicted %0d",
                                     $signed(data[15:0]), $signed(want.roll)));
                end
                if (data[30:16] !== want.pitch) begin
                    report($sformatf("pitch %0d, predicted %0d",
                                     $signed(data[30:16]), $signed(want.pitch)));
                end
                if (data[31] !== 1'b0) begin
                    report("pad bit of result not zero");
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // roll_centideg[15:0], pitch_centideg[30:16], zero[31]

    tilt_scoreboard board = new();
    int unsigned    rx_cycle = 0;

    accel_tilt_roll_pitch DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall pattern: always ready, coin flip, a stall whenever rx_cycle is a multiple of five, mostly ready
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle >> 8) & 3)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                i_m_axis_tready <= (rx_cycle % 5) != 0;
            end
            default: begin
                i_m_axis_tready <= $urandom_range(0, 3) != 0;
            end
        endcase
    end

    // result monitor: outputs are stable at the falling edge before the accepting edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata);
        end
    end

    // present one item and hold it until it is taken; called right after a rising edge
    task automatic send_sample(input logic [47:0] sample);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= sample;
        @(negedge i_clk);
        while (o_s_axis_tready !== 1'b1) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        board.note_sample(sample);
    endtask

    task automatic sender_gap(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // one axis value, mixing full range, small, extreme and moderate values
    function automatic logic [15:0] pick_axis();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            return 16'($urandom);
        end else if (kind < 7) begin
            return 16'($signed($urandom_range(0, 8)) - 4);
        end else if (kind < 8) begin
            case ($urandom_range(0, 5))
                0: return 16'h8000;
                1: return 16'h8001;
                2: return 16'hffff;
                3: return 16'h0000;
                4: return 16'h0001;
                default: return 16'h7fff;
            endcase
        end else begin
            return 16'($signed($urandom_range(0, 4000)) - 2000);
        end
    endfunction

    localparam logic [15:0] AX_MIN = 16'h8000;
    localparam logic [15:0] AX_MAX = 16'h7fff;

    initial begin
        logic [47:0] directed [$];
        int          burst_left;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed samples, packed as {z, y, x}
        directed = '{
            {16'd0, 16'd0, 16'd0},              // all operands zero
            {16'd0, 16'd0, AX_MIN},             // most negative x, roll operands zero
            {16'd0, 16'd0, AX_MAX},
            {16'hffff, 16'd0, 16'd0},           // negative z on the axis
            {AX_MIN, 16'd0, 16'd5},
            {16'd1, 16'd0, 16'd0},
            {16'd0, 16'd1, 16'd0},
            {16'd0, 16'hffff, 16'd0},
            {16'd0, AX_MIN, AX_MIN},
            {AX_MIN, AX_MIN, AX_MIN},
            {AX_MAX, AX_MAX, AX_MAX},
            {AX_MIN, AX_MAX, AX_MIN},
            {AX_MAX, AX_MIN, AX_MAX},
            {AX_MIN, 16'hffff, 16'd0},          // just below the negative z axis
            {AX_MIN, 16'd1, 16'd0},             // just above it
            {AX_MAX, 16'd0, AX_MIN},
            {16'd0, AX_MAX, 16'd1},
            {16'hfff9, 16'hfffd, 16'd5},
            {16'd16384, 16'd0, 16'd0},          // flat, one g on z
            {16'd11585, 16'd11585, 16'd0},
            {16'd0, 16'd0, 16'd1},
            {16'd0, 16'd0, 16'hffff}
        };
        foreach (directed[k]) begin
            send_sample(directed[k]);
        end
        sender_gap(3);

        // random samples in bursts with gaps of random length
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < 700; n++) begin
            if (n == 350) begin
                // drain everything before carrying on
                i_s_axis_tvalid <= 1'b0;
                while (board.pending.size() != 0) begin
                    @(posedge i_clk);
                end
            end
            send_sample({pick_axis(), pick_axis(), pick_axis()});
            burst_left--;
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0) begin
                    sender_gap($urandom_range(1, 7));
                end
                burst_left = $urandom_range(1, 24);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (80) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #800000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
